// File: design/wio_pkg.sv
// Package for the wheel and IMU odometry integrator: sequencer control word,
// microcode program, register indexes, CORDIC arctangent table and heading constants.
// Depends on nothing; used by wheel_imu_odometry_integrator.
package wio_pkg;

   // Datapath operation selected by the current control word.
   typedef enum logic [2:0] {
      OP_NOP,
      OP_FETCH,
      OP_SETUP,
      OP_ROTATE,
      OP_SCALE,
      OP_MUL_X,
      OP_MUL_Y,
      OP_COMMIT
   } op_type;

   // Condition that keeps the step counter on the current step.
   typedef enum logic [1:0] {
      STAY_NEVER,
      STAY_NO_WORK,
      STAY_ITER_MORE,
      STAY_OUT_BUSY
   } stay_type;

   // Configuration register indexes.
   typedef enum logic {
      CSR_IMU_PRESENT,
      CSR_DISTANCE_GAIN
   } csr_index_type;

   localparam int StepW = 3;
   typedef logic [StepW-1:0] step_type;

   typedef struct packed {
      op_type   op;
      stay_type stay;
      logic     jump;
      step_type target;
   } ctrl_word_type;

   localparam step_type STEP_FETCH  = 3'd0;
   localparam step_type STEP_SETUP  = 3'd1;
   localparam step_type STEP_ROTATE = 3'd2;
   localparam step_type STEP_SCALE  = 3'd3;
   localparam step_type STEP_MUL_X  = 3'd4;
   localparam step_type STEP_MUL_Y  = 3'd5;
   localparam step_type STEP_COMMIT = 3'd6;

   // Heading in 1/16 degree.
   localparam logic signed [14:0] YAW_FULL    = 15'sd5760;
   localparam logic signed [14:0] YAW_HALF    = 15'sd2880;
   localparam logic signed [14:0] YAW_QUARTER = 15'sd1440;

   // CORDIC gain compensation 0.6072529350 in Q4.30.
   localparam int CordW = 34;
   localparam logic signed [CordW-1:0] CORDIC_X0 = 34'sd652032874;

   localparam int AngW = 29;
   localparam int AtanW = 28;

   // atan(2^-i) in units of 2^-20 degree.
   function automatic logic [AtanW-1:0] atan_rom(input logic [4:0] idx);
      logic [AtanW-1:0] v;
      case (idx)
         5'd0:  v = 28'd47185920;
         5'd1:  v = 28'd27855475;
         5'd2:  v = 28'd14718068;
         5'd3:  v = 28'd7471121;
         5'd4:  v = 28'd3750058;
         5'd5:  v = 28'd1876857;
         5'd6:  v = 28'd938658;
         5'd7:  v = 28'd469357;
         5'd8:  v = 28'd234682;
         5'd9:  v = 28'd117342;
         5'd10: v = 28'd58671;
         5'd11: v = 28'd29335;
         5'd12: v = 28'd14668;
         5'd13: v = 28'd7334;
         5'd14: v = 28'd3667;
         5'd15: v = 28'd1833;
         5'd16: v = 28'd917;
         5'd17: v = 28'd458;
         5'd18: v = 28'd229;
         5'd19: v = 28'd115;
         5'd20: v = 28'd57;
         5'd21: v = 28'd29;
         5'd22: v = 28'd14;
         5'd23: v = 28'd7;
         default: v = '0;
      endcase
      return v;
   endfunction

   // Microcode program: one control word per step.
   function automatic ctrl_word_type ucode_rom(input step_type step);
      ctrl_word_type w;
      unique case (step)
         STEP_FETCH:  w = '{op: OP_FETCH,  stay: STAY_NO_WORK,   jump: 1'b0, target: STEP_FETCH};
         STEP_SETUP:  w = '{op: OP_SETUP,  stay: STAY_NEVER,     jump: 1'b0, target: STEP_FETCH};
         STEP_ROTATE: w = '{op: OP_ROTATE, stay: STAY_ITER_MORE, jump: 1'b0, target: STEP_FETCH};
         STEP_SCALE:  w = '{op: OP_SCALE,  stay: STAY_NEVER,     jump: 1'b0, target: STEP_FETCH};
         STEP_MUL_X:  w = '{op: OP_MUL_X,  stay: STAY_NEVER,     jump: 1'b0, target: STEP_FETCH};
         STEP_MUL_Y:  w = '{op: OP_MUL_Y,  stay: STAY_NEVER,     jump: 1'b0, target: STEP_FETCH};
         STEP_COMMIT: w = '{op: OP_COMMIT, stay: STAY_OUT_BUSY,  jump: 1'b1, target: STEP_FETCH};
         default:     w = '{op: OP_NOP,    stay: STAY_NEVER,     jump: 1'b1, target: STEP_FETCH};
      endcase
      return w;
   endfunction

endpackage

// File: design/wheel_imu_odometry_integrator.sv
// Top level of the wheel and IMU odometry integrator: microcoded sequencer
// driving a CORDIC, two multiplies and the position accumulators.
// Depends on wio_pkg.
//
//   channel | ports                              | direction
//   --------+------------------------------------+-----------------------
//   req     | req_valid/req_ready, speeds, yaw   | in, one transfer a tick
//   rsp     | rsp_valid/rsp_ready, position, echo| out, zero or one a tick
//   csr     | csr_we, csr_index, csr_wdata       | in, write only
//
// A tick runs fetch, setup, rotate, scale, the two multiplies and commit in
// order; the rotate step runs one CORDIC rotation per cycle on a single shared unit.
// The next request transfer is taken once the result has been loaded into
// the output register, so a waiting result does not hold back the next tick
// unless a second result would overwrite it. With imu_present clear, a
// request is taken and dropped. Reset is synchronous and clears the positions,
// the held yaw and the registers to their defaults.
module wheel_imu_odometry_integrator #(
   parameter int ACC_WIDTH       = 48,
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_speed_left_rpm,
   input  logic signed [15:0] req_speed_right_rpm,
   input  logic signed [13:0] req_yaw_sixteenths,
   input  logic               req_yaw_valid,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_position_x,
   output logic signed [47:0] rsp_position_y,
   output logic signed [13:0] rsp_heading_sixteenths,
   output logic signed [15:0] rsp_echo_left_rpm,
   output logic signed [15:0] rsp_echo_right_rpm,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic        [23:0] csr_wdata
);

   localparam int IterW = (TRIG_ITERATIONS > 1) ? $clog2(TRIG_ITERATIONS) : 1;
   localparam logic [IterW-1:0] IterLast = IterW'(TRIG_ITERATIONS - 1);
   localparam int CordW = wio_pkg::CordW;
   localparam int AngW  = wio_pkg::AngW;
   localparam int DistW = 42;
   localparam int ProdW = DistW + 16;
   localparam int DeltaW = ProdW - 23;

   // Rounds a Q4.30 value half up to Q1.15 and saturates it.
   function automatic logic signed [15:0] to_q15(input logic signed [CordW-1:0] v);
      logic signed [CordW-1:0] t;
      logic signed [CordW-16:0] r;
      logic signed [15:0] q;
      t = v + CordW'(1 << 14);
      r = t[CordW-1:15];
      if (r > (CordW-15)'(32767))       q = 16'sh7FFF;
      else if (r < -(CordW-15)'(32768)) q = 16'sh8000;
      else                              q = r[15:0];
      return q;
   endfunction

   wio_pkg::ctrl_word_type ctrl;
   wio_pkg::step_type      pc_ff, pc_in;

   logic                    imu_present_ff, imu_present_in;
   logic [23:0]             gain_ff, gain_in;
   logic signed [13:0]      held_yaw_ff, held_yaw_in;
   logic [ACC_WIDTH-1:0]    pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [15:0]      left_ff, left_in, right_ff, right_in;
   logic signed [16:0]      sum_ff, sum_in;
   logic signed [DistW-1:0] dist_ff, dist_in;
   logic signed [CordW-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [AngW-1:0]  cz_ff, cz_in;
   logic                    neg_ff, neg_in;
   logic [IterW-1:0]        iter_ff, iter_in;
   logic signed [15:0]      cos_ff, cos_in, sin_ff, sin_in;
   logic signed [ProdW-1:0] prod_ff, prod_in;
   logic [ACC_WIDTH-1:0]    dx_ff, dx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [47:0]      out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic signed [13:0]      out_yaw_ff, out_yaw_in;
   logic signed [15:0]      out_left_ff, out_left_in, out_right_ff, out_right_in;

   logic req_xfer;
   logic slot_free;
   logic stay;

   logic signed [14:0]      yaw_wide, yaw_red, yaw_fold;
   logic                    yaw_neg;
   logic signed [CordW-1:0] cx_shift, cy_shift;
   logic signed [AngW-1:0]  atan_val;
   logic signed [ProdW-1:0] prod_rnd;
   logic signed [DeltaW-1:0] delta;
   logic signed [63:0]      delta_ext, pos_x_ext, pos_y_ext;
   logic [ACC_WIDTH-1:0]    pos_x_sum, pos_y_sum;

   assign ctrl      = wio_pkg::ucode_rom(pc_ff);
   assign req_ready = (ctrl.op == wio_pkg::OP_FETCH);
   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Sequencer: stay, jump or fall through to the next step.
   always_comb begin
      unique case (ctrl.stay)
         wio_pkg::STAY_NEVER:     stay = 1'b0;
         wio_pkg::STAY_NO_WORK:   stay = !(req_valid && imu_present_ff);
         wio_pkg::STAY_ITER_MORE: stay = (iter_ff != IterLast);
         wio_pkg::STAY_OUT_BUSY:  stay = !slot_free;
         default:                 stay = 1'b0;
      endcase
      if (stay)           pc_in = pc_ff;
      else if (ctrl.jump) pc_in = ctrl.target;
      else                pc_in = pc_ff + 1'b1;
   end

   // Heading reduction to +-180 degrees and fold into +-90 degrees.
   always_comb begin
      yaw_wide = 15'(held_yaw_ff);
      if (yaw_wide > wio_pkg::YAW_HALF)       yaw_red = yaw_wide - wio_pkg::YAW_FULL;
      else if (yaw_wide < -wio_pkg::YAW_HALF) yaw_red = yaw_wide + wio_pkg::YAW_FULL;
      else                                    yaw_red = yaw_wide;
      yaw_neg = 1'b1;
      if (yaw_red > wio_pkg::YAW_QUARTER)       yaw_fold = yaw_red - wio_pkg::YAW_HALF;
      else if (yaw_red < -wio_pkg::YAW_QUARTER) yaw_fold = yaw_red + wio_pkg::YAW_HALF;
      else begin
         yaw_fold = yaw_red;
         yaw_neg  = 1'b0;
      end
   end

   assign cx_shift = cx_ff >>> iter_ff;
   assign cy_shift = cy_ff >>> iter_ff;
   assign atan_val = AngW'(wio_pkg::atan_rom(5'(iter_ff)));

   // Rounding of a product from Q.39 down to Q.16, then wrap to the accumulator.
   assign prod_rnd  = prod_ff + ProdW'(1 << 22);
   assign delta     = prod_rnd[ProdW-1:23];
   assign delta_ext = 64'(delta);
   assign pos_x_sum = pos_x_ff + dx_ff;
   assign pos_y_sum = pos_y_ff + delta_ext[ACC_WIDTH-1:0];
   assign pos_x_ext = 64'(signed'(pos_x_sum));
   assign pos_y_ext = 64'(signed'(pos_y_sum));

   // Datapath, one operation per control word.
   always_comb begin
      imu_present_in = imu_present_ff;
      gain_in        = gain_ff;
      held_yaw_in    = held_yaw_ff;
      pos_x_in       = pos_x_ff;
      pos_y_in       = pos_y_ff;
      left_in        = left_ff;
      right_in       = right_ff;
      sum_in         = sum_ff;
      dist_in        = dist_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      cz_in          = cz_ff;
      neg_in         = neg_ff;
      iter_in        = iter_ff;
      cos_in         = cos_ff;
      sin_in         = sin_ff;
      prod_in        = prod_ff;
      dx_in          = dx_ff;
      out_x_in       = out_x_ff;
      out_y_in       = out_y_ff;
      out_yaw_in     = out_yaw_ff;
      out_left_in    = out_left_ff;
      out_right_in   = out_right_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;

      if (csr_we) begin
         unique case (csr_index)
            wio_pkg::CSR_IMU_PRESENT:   imu_present_in = csr_wdata[0];
            wio_pkg::CSR_DISTANCE_GAIN: gain_in        = csr_wdata;
            default:                    gain_in        = gain_ff;
         endcase
      end

      unique case (ctrl.op)
         wio_pkg::OP_FETCH: begin
            // With integration disabled the transfer is taken and dropped.
            if (req_xfer && imu_present_ff) begin
               left_in  = req_speed_left_rpm;
               right_in = req_speed_right_rpm;
               sum_in   = 17'(req_speed_left_rpm) + 17'(req_speed_right_rpm);
               if (req_yaw_valid) held_yaw_in = req_yaw_sixteenths;
            end
         end
         wio_pkg::OP_SETUP: begin
            dist_in = sum_ff * $signed({1'b0, gain_ff});
            cx_in   = wio_pkg::CORDIC_X0;
            cy_in   = '0;
            cz_in   = {yaw_fold[AngW-17:0], 16'h0000};
            neg_in  = yaw_neg;
            iter_in = '0;
         end
         wio_pkg::OP_ROTATE: begin
            if (!cz_ff[AngW-1]) begin
               cx_in = cx_ff - cy_shift;
               cy_in = cy_ff + cx_shift;
               cz_in = cz_ff - atan_val;
            end else begin
               cx_in = cx_ff + cy_shift;
               cy_in = cy_ff - cx_shift;
               cz_in = cz_ff + atan_val;
            end
            iter_in = iter_ff + 1'b1;
         end
         wio_pkg::OP_SCALE: begin
            cos_in = to_q15(neg_ff ? -cx_ff : cx_ff);
            sin_in = to_q15(neg_ff ? -cy_ff : cy_ff);
         end
         wio_pkg::OP_MUL_X: begin
            prod_in = dist_ff * cos_ff;
         end
         wio_pkg::OP_MUL_Y: begin
            dx_in   = delta_ext[ACC_WIDTH-1:0];
            prod_in = dist_ff * sin_ff;
         end
         wio_pkg::OP_COMMIT: begin
            if (slot_free) begin
               pos_x_in     = pos_x_sum;
               pos_y_in     = pos_y_sum;
               out_x_in     = pos_x_ext[47:0];
               out_y_in     = pos_y_ext[47:0];
               out_yaw_in   = held_yaw_ff;
               out_left_in  = left_ff;
               out_right_in = right_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            iter_in = iter_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff          <= wio_pkg::STEP_FETCH;
         imu_present_ff <= 1'b0;
         gain_ff        <= 24'd142746;
         held_yaw_ff    <= '0;
         pos_x_ff       <= '0;
         pos_y_ff       <= '0;
         iter_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         pc_ff          <= pc_in;
         imu_present_ff <= imu_present_in;
         gain_ff        <= gain_in;
         held_yaw_ff    <= held_yaw_in;
         pos_x_ff       <= pos_x_in;
         pos_y_ff       <= pos_y_in;
         iter_ff        <= iter_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff      <= left_in;
      right_ff     <= right_in;
      sum_ff       <= sum_in;
      dist_ff      <= dist_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      cz_ff        <= cz_in;
      neg_ff       <= neg_in;
      cos_ff       <= cos_in;
      sin_ff       <= sin_in;
      prod_ff      <= prod_in;
      dx_ff        <= dx_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_yaw_ff   <= out_yaw_in;
      out_left_ff  <= out_left_in;
      out_right_ff <= out_right_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_position_x         = out_x_ff;
   assign rsp_position_y         = out_y_ff;
   assign rsp_heading_sixteenths = out_yaw_ff;
   assign rsp_echo_left_rpm      = out_left_ff;
   assign rsp_echo_right_rpm     = out_right_ff;

endmodule
